// File: hw/rtl/sui_pkg.sv
// ----------------------------------------------------------------------------
// sui_pkg
// Shared constants and controller/datapath interface types for the set
// union and intersection block.
// ----------------------------------------------------------------------------
package sui_pkg;

    localparam int SET_SIZE  = 16;
    localparam int IDX_W     = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
    localparam int CNT_W     = $clog2(SET_SIZE + 1);
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(5);

    localparam logic WHICH_UNION = 1'b0;
    localparam logic WHICH_INTER = 1'b1;
    localparam logic REQ_A       = 1'b0;
    localparam logic REQ_B       = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // accepted request: store into A or B
        logic clr_i;
        logic inc_i;
        logic clr_j;
        logic inc_j;
        logic a_sel_j;     // A read address: 1 = j, 0 = i
        logic b_sel_j;     // B read address: 1 = j, 0 = i
        logic latch_cur;   // capture B[i] as the element under test
        logic cmp_a;       // compare element under test with A[j]
        logic cmp_b;       // compare element under test with B[j]
        logic push;        // queue one result
        logic push_cur;    // result value: 1 = element under test, 0 = A data
        logic push_which;
        logic mark_b;      // flag B[i] as added to the union
        logic flush;       // release last result, clear counts and flags
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic trig;        // current request completes set B
        logic i_lt_na;
        logic i_lt_nb;
        logic j_lt_na;
        logic j_lt_i;
        logic seen;
        logic hit_i;
    } t_status;

endpackage

// File: hw/rtl/sui_ram.sv
// ----------------------------------------------------------------------------
// sui_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sui_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sui_dp.sv
// ----------------------------------------------------------------------------
// sui_dp
// Datapath: set stores, counts, loop indexes, hit flags, compare logic and
// the result holding and output registers.
// ----------------------------------------------------------------------------
module sui_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sui_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_req_type,
    input  logic [sui_pkg::VAL_W-1:0]   i_value,
    input  sui_pkg::t_cmd               i_cmd,
    output sui_pkg::t_status            o_status,
    output logic                        o_res_valid,
    output logic                        o_which_set,
    output logic [sui_pkg::VAL_W-1:0]   o_value_res,
    output logic                        o_last
);

    logic [sui_pkg::CFG_W-1:0]    r_cfg;
    logic [sui_pkg::CNT_W-1:0]    r_a_count;
    logic [sui_pkg::CNT_W-1:0]    r_b_count;
    logic [sui_pkg::CNT_W-1:0]    r_i;
    logic [sui_pkg::CNT_W-1:0]    r_j;
    logic [sui_pkg::SET_SIZE-1:0] r_a_hit;
    logic [sui_pkg::SET_SIZE-1:0] r_b_added;
    logic                         r_seen;
    logic [sui_pkg::VAL_W-1:0]    r_cur;
    logic                         r_pend_v;
    logic                         r_pend_which;
    logic [sui_pkg::VAL_W-1:0]    r_pend_val;
    logic                         r_out_v;
    logic                         r_out_which;
    logic [sui_pkg::VAL_W-1:0]    r_out_val;
    logic                         r_out_last;

    logic [sui_pkg::CNT_W-1:0]    n_eff;
    logic [sui_pkg::CNT_W-1:0]    b_post;
    logic                         a_lt_n;
    logic                         b_lt_n;
    logic                         a_we;
    logic                         b_we;
    logic [sui_pkg::IDX_W-1:0]    a_raddr;
    logic [sui_pkg::IDX_W-1:0]    b_raddr;
    logic [sui_pkg::VAL_W-1:0]    a_rdata;
    logic [sui_pkg::VAL_W-1:0]    b_rdata;
    logic                         eq_a;
    logic                         eq_b;
    logic [sui_pkg::VAL_W-1:0]    push_val;

    // Clamp the configured size into 1..SET_SIZE
    always_comb begin
        priority if (r_cfg == '0) begin
            n_eff = sui_pkg::CNT_W'(1);
        end else if (r_cfg > sui_pkg::CFG_W'(sui_pkg::SET_SIZE)) begin
            n_eff = sui_pkg::CNT_W'(sui_pkg::SET_SIZE);
        end else begin
            n_eff = sui_pkg::CNT_W'(r_cfg);
        end
    end

    assign a_lt_n = (r_a_count < n_eff);
    assign b_lt_n = (r_b_count < n_eff);
    assign a_we   = i_cmd.load && (i_req_type == sui_pkg::REQ_A) && a_lt_n;
    assign b_we   = i_cmd.load && (i_req_type == sui_pkg::REQ_B) && b_lt_n;
    assign b_post = b_lt_n ? sui_pkg::CNT_W'(r_b_count + 1'b1) : r_b_count;

    assign a_raddr = i_cmd.a_sel_j ? r_j[sui_pkg::IDX_W-1:0] : r_i[sui_pkg::IDX_W-1:0];
    assign b_raddr = i_cmd.b_sel_j ? r_j[sui_pkg::IDX_W-1:0] : r_i[sui_pkg::IDX_W-1:0];

    sui_ram #(
        .WIDTH (sui_pkg::VAL_W),
        .DEPTH (sui_pkg::SET_SIZE)
    ) u_a_store (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_a_count[sui_pkg::IDX_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    sui_ram #(
        .WIDTH (sui_pkg::VAL_W),
        .DEPTH (sui_pkg::SET_SIZE)
    ) u_b_store (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (r_b_count[sui_pkg::IDX_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign eq_a     = (a_rdata == r_cur);
    assign eq_b     = (b_rdata == r_cur);
    assign push_val = i_cmd.push_cur ? r_cur : a_rdata;

    assign o_status.trig    = (i_req_type == sui_pkg::REQ_B) && (b_post >= n_eff);
    assign o_status.i_lt_na = (r_i < r_a_count);
    assign o_status.i_lt_nb = (r_i < r_b_count);
    assign o_status.j_lt_na = (r_j < r_a_count);
    assign o_status.j_lt_i  = (r_j < r_i);
    assign o_status.seen    = r_seen;
    assign o_status.hit_i   = r_a_hit[r_i[sui_pkg::IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= sui_pkg::CFG_RESET;
            r_a_count <= '0;
            r_b_count <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_a_hit   <= '0;
            r_b_added <= '0;
            r_seen    <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end

            priority if (i_cmd.flush) begin
                r_a_count <= '0;
                r_b_count <= '0;
            end else if (a_we) begin
                r_a_count <= sui_pkg::CNT_W'(r_a_count + 1'b1);
            end else if (b_we) begin
                r_b_count <= sui_pkg::CNT_W'(r_b_count + 1'b1);
            end

            priority if (i_cmd.clr_i || i_cmd.flush) begin
                r_i <= '0;
            end else if (i_cmd.inc_i) begin
                r_i <= sui_pkg::CNT_W'(r_i + 1'b1);
            end

            priority if (i_cmd.clr_j || i_cmd.flush) begin
                r_j <= '0;
            end else if (i_cmd.inc_j) begin
                r_j <= sui_pkg::CNT_W'(r_j + 1'b1);
            end

            priority if (i_cmd.latch_cur) begin
                r_seen <= 1'b0;
            end else if (i_cmd.cmp_a && eq_a) begin
                r_seen <= 1'b1;
            end else if (i_cmd.cmp_b && eq_b && r_b_added[r_j[sui_pkg::IDX_W-1:0]]) begin
                r_seen <= 1'b1;
            end

            priority if (i_cmd.flush) begin
                r_a_hit <= '0;
            end else if (i_cmd.cmp_a && eq_a) begin
                r_a_hit[r_j[sui_pkg::IDX_W-1:0]] <= 1'b1;
            end

            priority if (i_cmd.flush) begin
                r_b_added <= '0;
            end else if (i_cmd.mark_b) begin
                r_b_added[r_i[sui_pkg::IDX_W-1:0]] <= 1'b1;
            end

            // Hold one result back so the final one can carry last
            priority if (i_cmd.flush) begin
                r_out_v  <= r_pend_v;
                r_pend_v <= 1'b0;
            end else if (i_cmd.push) begin
                r_out_v  <= r_pend_v;
                r_pend_v <= 1'b1;
            end else begin
                r_out_v  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_cur) begin
            r_cur <= b_rdata;
        end
        if (i_cmd.push) begin
            r_pend_which <= i_cmd.push_which;
            r_pend_val   <= push_val;
        end
        if (i_cmd.push || i_cmd.flush) begin
            r_out_which <= r_pend_which;
            r_out_val   <= r_pend_val;
            r_out_last  <= i_cmd.flush;
        end
    end

    assign o_res_valid = r_out_v;
    assign o_which_set = r_out_which;
    assign o_value_res = r_out_val;
    assign o_last      = r_out_last;

    a_last_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_last) |-> $past(i_cmd.flush))
        else $error("last result not produced by a flush");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_a_count == '0) && (r_b_count == '0) && (r_a_hit == '0)
                        && (r_b_added == '0) && !r_pend_v)
        else $error("flush left state behind");

    a_mark_unseen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_b |-> !r_seen)
        else $error("B element marked although already present");

endmodule

// File: hw/rtl/sui_ctrl.sv
// ----------------------------------------------------------------------------
// sui_ctrl
// Controller: accepts requests while idle and sequences the result run
// (union of A, new B elements, intersection) over the datapath.
// ----------------------------------------------------------------------------
module sui_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sui_pkg::t_status  i_status,
    output sui_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_UA_RD  = 13'b0000000000010,
        S_UA_USE = 13'b0000000000100,
        S_B_RD   = 13'b0000000001000,
        S_B_CUR  = 13'b0000000010000,
        S_SA_RD  = 13'b0000000100000,
        S_SA_USE = 13'b0000001000000,
        S_SB_RD  = 13'b0000010000000,
        S_SB_USE = 13'b0000100000000,
        S_B_ADD  = 13'b0001000000000,
        S_I_RD   = 13'b0010000000000,
        S_I_USE  = 13'b0100000000000,
        S_FLUSH  = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_status.trig) begin
                        n_state = S_UA_RD;
                    end
                end
            end
            S_UA_RD: begin
                if (i_status.i_lt_na) begin
                    n_state = S_UA_USE;
                end else begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = S_B_RD;
                end
            end
            S_UA_USE: begin
                o_cmd.push       = 1'b1;
                o_cmd.push_which = sui_pkg::WHICH_UNION;
                o_cmd.inc_i      = 1'b1;
                n_state          = S_UA_RD;
            end
            S_B_RD: begin
                if (i_status.i_lt_nb) begin
                    n_state = S_B_CUR;
                end else begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = S_I_RD;
                end
            end
            S_B_CUR: begin
                o_cmd.latch_cur = 1'b1;
                o_cmd.clr_j     = 1'b1;
                n_state         = S_SA_RD;
            end
            S_SA_RD: begin
                o_cmd.a_sel_j = 1'b1;
                if (i_status.j_lt_na) begin
                    n_state = S_SA_USE;
                end else begin
                    o_cmd.clr_j = 1'b1;
                    n_state     = S_SB_RD;
                end
            end
            S_SA_USE: begin
                o_cmd.cmp_a = 1'b1;
                o_cmd.inc_j = 1'b1;
                n_state     = S_SA_RD;
            end
            S_SB_RD: begin
                o_cmd.b_sel_j = 1'b1;
                if (i_status.j_lt_i) begin
                    n_state = S_SB_USE;
                end else begin
                    n_state = S_B_ADD;
                end
            end
            S_SB_USE: begin
                o_cmd.cmp_b = 1'b1;
                o_cmd.inc_j = 1'b1;
                n_state     = S_SB_RD;
            end
            S_B_ADD: begin
                if (!i_status.seen) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.push_cur   = 1'b1;
                    o_cmd.push_which = sui_pkg::WHICH_UNION;
                    o_cmd.mark_b     = 1'b1;
                end
                o_cmd.inc_i = 1'b1;
                n_state     = S_B_RD;
            end
            S_I_RD: begin
                if (i_status.i_lt_na) begin
                    n_state = S_I_USE;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_I_USE: begin
                if (i_status.hit_i) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.push_which = sui_pkg::WHICH_INTER;
                end
                o_cmd.inc_i = 1'b1;
                n_state     = S_I_RD;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_trig_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && i_start && i_status.trig) |=> (r_state == S_UA_RD))
        else $error("completed set B did not start a run");

    a_flush_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (r_state == S_IDLE))
        else $error("run did not end after flush");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE) && !o_busy)
        else $error("request stored while a run is active");

endmodule

// File: hw/rtl/set_union_intersection.sv
// ----------------------------------------------------------------------------
// set_union_intersection
// Loading a request (A or B element) leaves busy low.
// The request that completes set B starts a run, with busy high until it ends; the
// single read port of each set store makes every compare a read state followed
// by a use state. Results come out as one-cycle strobes, the last marked, the
// receiver cannot stall them.
// Synchronous active-low reset clears counts and flags; set size resets to 5.
// ----------------------------------------------------------------------------
module set_union_intersection (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sui_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [sui_pkg::VAL_W-1:0]   i_value,
    output logic                        o_res_valid,
    output logic                        o_which_set,
    output logic [sui_pkg::VAL_W-1:0]   o_value_res,
    output logic                        o_last
);

    sui_pkg::t_cmd    cmd;
    sui_pkg::t_status status;

    sui_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sui_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res_valid (o_res_valid),
        .o_which_set (o_which_set),
        .o_value_res (o_value_res),
        .o_last      (o_last)
    );

endmodule
